FILE: hdl/signed_int_to_decimal_ascii_unit_macros.svh
// Assertion macros for the conversion unit's RTL files.
// No dependencies; included by files that carry concurrent checks.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// ante |-> cons in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
// ante |=> cons in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
// expr never true
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

FILE: hdl/sidau_pkg.sv
// Types and constants for the signed integer to decimal ASCII unit.
// No dependencies.
`timescale 1ns / 1ps

package sidau_pkg;

    localparam int NUM_DIGITS = 10;

    localparam logic [5:0]  ASCII_ZERO  = 6'd48;
    localparam logic [5:0]  ASCII_MINUS = 6'd45;
    // ceil(2^35 / 10): floor(x / 10) == (x * RECIP_10) >> 35 for any 32-bit x
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;

    typedef logic [3:0] digit_t;
    typedef logic [3:0] idx_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] code;
        logic       last;
    } char_t;

endpackage

FILE: hdl/sidau_div10.sv
// Shared divide-by-ten unit: reciprocal multiply, remainder from low bits.
// Depends on sidau_pkg.
`timescale 1ns / 1ps

module sidau_div10 (
    input  logic [31:0]       dividend,
    output logic [31:0]       quotient,
    output sidau_pkg::digit_t remainder
);
    import sidau_pkg::*;

    logic [63:0] product;
    logic [3:0]  q_times_ten;

    assign product  = {32'd0, dividend} * {32'd0, RECIP_10};
    assign quotient = {3'd0, product[63:35]};

    // remainder < 10, so only the low nibble of q*10 matters
    assign q_times_ten = {quotient[0], 3'd0} + {quotient[2:0], 1'b0};
    assign remainder   = dividend[3:0] - q_times_ten;

endmodule

FILE: hdl/sidau_seq.sv
// Sequencer: digit extraction through the shared divider, then character emission.
// Depends on sidau_pkg, sidau_div10 and the assertion macro header.
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_unit_macros.svh"

module sidau_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] value,
    input  logic               emit_ok,
    output sidau_pkg::char_t   ch
);
    import sidau_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic        sign_reg, sign_next;
    idx_t        idx_reg, idx_next;
    logic [31:0] mag_reg, mag_next;
    digit_t      digits_reg [NUM_DIGITS];

    logic [31:0] quotient;
    digit_t      remainder;
    logic [31:0] value_u;
    logic        accept;
    logic        div_done;

    sidau_div10 u_div10 (
        .dividend  (mag_reg),
        .quotient  (quotient),
        .remainder (remainder)
    );

    assign value_u  = value;
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign div_done = (quotient == 32'd0);

    always_comb
    begin
        ch.valid = (state_reg == ST_EMIT) && emit_ok;
        ch.code  = sign_reg ? ASCII_MINUS : (ASCII_ZERO + {2'd0, digits_reg[idx_reg]});
        ch.last  = !sign_reg && (idx_reg == idx_t'(0));
    end

    always_comb
    begin
        state_next = state_reg;
        sign_next  = sign_reg;
        idx_next   = idx_reg;
        mag_next   = mag_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sign_next  = value_u[31];
                    mag_next   = value_u[31] ? (~value_u + 32'd1) : value_u;
                    idx_next   = idx_t'(0);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                mag_next = quotient;
                if (div_done)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + idx_t'(1);
                end
            end
            ST_EMIT:
            begin
                if (emit_ok)
                begin
                    if (sign_reg)
                    begin
                        sign_next = 1'b0;
                    end
                    else if (idx_reg == idx_t'(0))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - idx_t'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sign_reg  <= 1'b0;
            idx_reg   <= idx_t'(0);
        end
        else
        begin
            state_reg <= state_next;
            sign_reg  <= sign_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        if (state_reg == ST_DIV)
        begin
            digits_reg[idx_reg] <= remainder;
        end
    end

    `ASSERT_IMPL(a_idx_in_range, clk, rst_n, state_reg != ST_IDLE, idx_reg < idx_t'(NUM_DIGITS))
    `ASSERT_NEXT(a_accept_starts_div, clk, rst_n, accept, state_reg == ST_DIV)
    `ASSERT_NEXT(a_last_ends_run, clk, rst_n, ch.valid && ch.last, state_reg == ST_IDLE)
    `ASSERT_NEVER(a_sign_only_first, clk, rst_n, (state_reg == ST_IDLE) && sign_reg)

endmodule

FILE: hdl/signed_int_to_decimal_ascii_unit.sv
// Signed 32-bit integer to decimal ASCII text, one character per output request,
// most significant first, with a leading minus for negative values and the last
// character flagged. An accepted value is loaded, then its decimal digits (1 to 10)
// are found one at a time through the shared divide-by-ten multiplier, then its
// characters (1 to 11) are sent one at a time through the output register, which
// waits while the output is held off. in_ready is high only between values.
// Depends on sidau_pkg, sidau_seq and sidau_div10.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [5:0]         char_code,
    output logic               last_char
);
    import sidau_pkg::*;

    char_t      ch;
    logic       emit_ok;
    logic       out_valid_reg;
    logic [5:0] code_reg;
    logic       last_reg;

    assign emit_ok = !out_valid_reg || out_ready;

    sidau_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .value    (value),
        .emit_ok  (emit_ok),
        .ch       (ch)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ch.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ch.valid)
        begin
            code_reg <= ch.code;
            last_reg <= ch.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign char_code = code_reg;
    assign last_char = last_reg;

endmodule

FILE: sim/decimal_text_checker.sv
// Scoreboard for the signed integer to decimal ASCII unit: predicts the text of every
// accepted value and compares each character request against it.
// Depends on sidau_pkg for the character codes.
`timescale 1ns / 1ps

module decimal_text_checker
    import sidau_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [31:0] value,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [5:0]  char_code,
    input  logic        last_char,
    output int          mismatches,
    output int          pending,
    output int          chars_seen
);

    typedef struct {
        logic [5:0] code;
        logic       last;
    } text_char_t;

    text_char_t expected_text [$];
    int         error_count = 0;
    int         char_count  = 0;

    function automatic void queue_decimal_text(input logic [31:0] v);
        logic [31:0] mag;
        logic [3:0]  digs [10];
        int          n;
        mag = v[31] ? (32'd0 - v) : v;
        n = 0;
        do
        begin
            digs[n] = 4'(mag % 32'd10);
            mag = mag / 32'd10;
            n++;
        end
        while (mag != 0);
        if (v[31])
        begin
            expected_text.push_back('{ASCII_MINUS, 1'b0});
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            expected_text.push_back('{6'(ASCII_ZERO + digs[i]), i == 0});
        end
    endfunction

    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                queue_decimal_text(value);
            end
            if (out_valid && out_ready)
            begin
                char_count++;
                if (expected_text.size() == 0)
                begin
                    if (error_count < 10)
                    begin
                        $display("%0t: unexpected character request code=%0d last=%0b",
                                 $realtime, char_code, last_char);
                    end
                    error_count++;
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (char_code !== want.code || last_char !== want.last)
                    begin
                        if (error_count < 10)
                        begin
                            $display("%0t: char mismatch: expected %0d/%0b, got %0d/%0b",
                                     $realtime, want.code, want.last,
                                     char_code, last_char);
                        end
                        error_count++;
                    end
                end
            end
        end
        mismatches <= error_count;
        pending    <= expected_text.size();
        chars_seen <= char_count;
    end

endmodule

FILE: sim/tb_signed_int_to_decimal_ascii_unit.sv
// Testbench top for signed_int_to_decimal_ascii_unit: drives directed and random values
// under random backpressure and gives the verdict.
// Depends on the RTL and on decimal_text_checker.
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii_unit;

    localparam int          LONG_HOLD = 120;
    localparam int unsigned DECADE [10] = '{
        32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
        32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
    };
    localparam logic [31:0] CORNER [23] = '{
        32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100,
        -32'sd100, 32'd12345, -32'sd54321, 32'd999999, 32'd1000000, 32'd99999999,
        -32'sd100000000, 32'd999999999, -32'sd999999999, 32'd1000000000,
        -32'sd1000000000, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] value;
    logic        out_valid;
    logic        out_ready;
    logic [5:0]  char_code;
    logic        last_char;

    int mismatches;
    int pending;
    int chars_seen;
    int items_sent = 0;
    bit steady     = 1'b0;
    bit hold_req   = 1'b0;

    signed_int_to_decimal_ascii_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_code (char_code),
        .last_char (last_char)
    );

    decimal_text_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .char_code  (char_code),
        .last_char  (last_char),
        .mismatches (mismatches),
        .pending    (pending),
        .chars_seen (chars_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("signed_int_to_decimal_ascii_unit test failed");
        $finish;
    end

    // receiver: random stall bursts, one long hold-off on request, none in the final part
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (!steady && $urandom_range(0, 4) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            else
            begin
                out_ready = 1'b1;
                repeat ($urandom_range(1, 40)) @(negedge clk);
            end
        end
    end

    function automatic logic [31:0] pick_value();
        int unsigned k;
        logic [31:0] v;
        k = $urandom_range(0, 9);
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = $urandom % DECADE[k];
            2: v = DECADE[k] - $urandom_range(0, 1);
            3: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: v = $urandom_range(0, 30);
        endcase
        if ($urandom_range(0, 1))
        begin
            v = 32'd0 - v;
        end
        return v;
    endfunction

    // called at a falling edge; returns at the falling edge after the request is taken
    task automatic send_value(input logic [31:0] v, input bit may_idle);
        if (may_idle && !steady && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        in_valid = 1'b1;
        value    = v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    initial
    begin
        in_valid = 1'b0;
        value    = '0;
        rst_n    = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (CORNER[i])
        begin
            send_value(CORNER[i], 1'b1);
        end

        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);

        hold_req = 1'b1;
        repeat (30) send_value(pick_value(), 1'b0);

        repeat (330) send_value(pick_value(), 1'b1);

        steady = 1'b1;
        repeat (40) send_value(pick_value(), 1'b1);

        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (40) @(posedge clk);

        $display("Converted %0d values (corner values, long output stall, random sizes and signs)",
                 items_sent);
        $display("into %0d checked characters, %0d mismatches", chars_seen, mismatches);
        if (mismatches == 0 && pending == 0)
        begin
            $display("signed_int_to_decimal_ascii_unit test passed");
        end
        else
        begin
            $display("signed_int_to_decimal_ascii_unit test failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/sidau_pkg.sv
hdl/sidau_div10.sv
hdl/sidau_seq.sv
hdl/signed_int_to_decimal_ascii_unit.sv
sim/decimal_text_checker.sv
sim/tb_signed_int_to_decimal_ascii_unit.sv
